[sv/vam_pkg.sv]
package vam_pkg;

  localparam int NUM_VOICES = 8;
  localparam int VIDX_W     = 3;
  localparam int CNT_W      = 4;
  localparam int LVL_W      = 14;

  localparam logic [3:0] ST_NOTE_OFF = 4'h8;
  localparam logic [3:0] ST_NOTE_ON  = 4'h9;
  localparam logic [3:0] ST_POLY_AT  = 4'hA;
  localparam logic [3:0] ST_CTRL     = 4'hB;
  localparam logic [3:0] ST_SYSTEM   = 4'hF;

  localparam logic [7:0] CC_HIRES_VEL  = 8'h58;
  localparam logic [7:0] CC_SOUND_OFF  = 8'h78;
  localparam logic [7:0] CC_NOTES_OFF  = 8'h7B;
  localparam logic [7:0] CC_OMNI_OFF   = 8'h7C;
  localparam logic [7:0] CC_OMNI_ON    = 8'h7D;
  localparam logic [7:0] CC_MONO_ON    = 8'h7E;
  localparam logic [7:0] CC_POLY_ON    = 8'h7F;

  localparam logic [LVL_W-1:0] HALF_LEVEL = 14'd8192;

  localparam logic [1:0] REG_KEY_ROOT  = 2'd0;
  localparam logic [1:0] REG_CHROMATIC = 2'd1;
  localparam logic [1:0] REG_CHANNEL   = 2'd2;

  localparam logic [1:0] GATE_ON  = 2'b01;
  localparam logic [1:0] GATE_OFF = 2'b11;
  localparam logic [1:0] GATE_NIL = 2'b00;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DEC,
    S_SCAN,
    S_ACT,
    S_WR,
    S_REP,
    S_ANO_EMIT,
    S_ANO_PUSH
  } state_t;

  typedef enum logic [1:0] {
    OP_ON,
    OP_OFF,
    OP_PRESS
  } op_t;

  typedef struct packed {
    logic signed [8:0] pitch;
    logic [LVL_W-1:0]  attack;
    logic [LVL_W-1:0]  release_lvl;
    logic [LVL_W-1:0]  pressure;
  } voice_rec_t;

  typedef struct packed {
    logic              rm;
    logic [VIDX_W-1:0] rm_pos;
    logic              push;
    logic [VIDX_W-1:0] push_val;
    logic              clr;
  } q_op_t;

  function automatic logic [3:0] degree_half(input logic [3:0] rem);
    logic [3:0] r;
    begin
      case (rem)
        4'd0:    r = 4'd0;
        4'd1:    r = 4'd1;
        4'd2:    r = 4'd2;
        4'd3:    r = 4'd3;
        4'd4:    r = 4'd4;
        4'd5:    r = 4'd6;
        4'd6:    r = 4'd7;
        4'd7:    r = 4'd8;
        4'd8:    r = 4'd9;
        4'd9:    r = 4'd10;
        4'd10:   r = 4'd11;
        4'd11:   r = 4'd12;
        default: r = 4'd0;
      endcase
      return r;
    end
  endfunction

  // Octave split by reciprocal multiply: x = d + 132 stays in 5..259.
  function automatic logic signed [8:0] to_pitch(input logic [6:0] note,
                                                 input logic [6:0] root,
                                                 input logic       chrom);
    logic signed [7:0] d;
    logic [8:0]        x;
    logic [20:0]       prod;
    logic [4:0]        q;
    logic [8:0]        rem9;
    logic signed [5:0] oct;
    logic signed [8:0] res;
    begin
      d    = $signed({1'b0, note}) - $signed({1'b0, root});
      x    = {d[7], d} + 9'd132;
      prod = {12'd0, x} * 21'd2731;
      q    = prod[19:15];
      rem9 = x - {4'd0, q} * 9'd12;
      oct  = $signed({1'b0, q}) - 6'sd11;
      if (chrom) begin
        res = $signed({d, 1'b0});
      end else begin
        res = $signed({{3{oct[5]}}, oct}) * 9'sd14
            + $signed({5'd0, degree_half(rem9[3:0])});
      end
      return res;
    end
  endfunction

endpackage

[sv/midi_voice_allocator_unit.sv]
// MIDI voice allocator. Raise start for one cycle while busy is low to hand
// over one item: a three-byte MIDI message (in_func = 0) or a frame tick
// (in_func = 1). Results leave as single-cycle strobes on out_valid and must
// be captured on that cycle: the receiver cannot stall the block, and out_last
// marks the final result of an item. Voice state sits in an eight-entry
// synchronous memory with a registered read port, so a note or aftertouch
// is a read-modify-write sequence. Busy stays high through decode alone for a
// message that does nothing; through decode, a pitch search over eight reads,
// then at most one read and one write for a note or aftertouch; through decode
// and eight reports for a tick; and through decode, a report for each sounding
// voice and a push-back of each for an all-notes-off style controller; the
// next item is taken on the first cycle busy is low.
// Configuration writes (index 0 key root, 1 chromatic, 2 channel) are taken
// whenever busy is low.
module midi_voice_allocator_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_func,
  input  logic [7:0]         in_status_byte,
  input  logic [7:0]         in_data_one,
  input  logic [7:0]         in_data_two,
  output logic               out_valid,
  output logic               out_kind,
  output logic [2:0]         out_voice,
  output logic signed [1:0]  out_gate,
  output logic signed [8:0]  out_pitch,
  output logic [13:0]        out_attack_level,
  output logic [13:0]        out_release_level,
  output logic [13:0]        out_pressure_level,
  output logic               out_last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [6:0]         cfg_data
);

  localparam int NV = vam_pkg::NUM_VOICES;
  localparam int VW = vam_pkg::VIDX_W;
  localparam int CW = vam_pkg::CNT_W;

  vam_pkg::state_t state_r, state_nxt;

  // Latched item and working registers.
  logic              func_r;
  logic [7:0]        st_r, d1_r, d2_r;
  vam_pkg::op_t      op_r, op_nxt;
  logic signed [8:0] pitch_r, pitch_nxt;
  logic [13:0]       level_r, level_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic [CW-1:0]     k_r, k_nxt;
  logic              found_r, found_nxt;
  logic [VW-1:0]     fv_r, fv_nxt;
  logic              match0_r, match0_nxt;
  logic [VW-1:0]     vcur_r, vcur_nxt;

  logic              pfx_valid_r, pfx_valid_nxt;
  logic [6:0]        pfx_r, pfx_nxt;
  logic              omni_r, omni_nxt;
  logic              mono_r, mono_nxt;

  logic [6:0]        key_root_r;
  logic              chromatic_r;
  logic [3:0]        channel_r;

  // Result register.
  logic              ov_r, ov_nxt;
  logic              ok_r, ok_nxt;
  logic [2:0]        ovc_r, ovc_nxt;
  logic [1:0]        og_r, og_nxt;
  vam_pkg::voice_rec_t orec_r, orec_nxt;
  logic              ol_r, ol_nxt;

  // Memory and queues.
  logic                  rd_en, wr_en, mem_clr;
  logic [VW-1:0]         rd_addr, wr_addr;
  vam_pkg::voice_rec_t   rd_data, wr_data;

  vam_pkg::q_op_t        sq_op, pq_op;
  logic [NV-1:0][VW-1:0] sq, pq;
  logic [CW-1:0]         sq_cnt, pq_cnt;
  logic                  sq_hit, pq_hit;
  logic [VW-1:0]         sq_pos, pq_pos;

  vam_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .clr     (mem_clr)
  );

  vam_queue #(.FILL_ON_RESET(1'b0)) u_started (
    .clk      (clk),
    .rst_n    (rst_n),
    .op       (sq_op),
    .find_val (fv_r),
    .entries  (sq),
    .cnt      (sq_cnt),
    .find_hit (sq_hit),
    .find_pos (sq_pos)
  );

  vam_queue #(.FILL_ON_RESET(1'b1)) u_stopped (
    .clk      (clk),
    .rst_n    (rst_n),
    .op       (pq_op),
    .find_val (fv_r),
    .entries  (pq),
    .cnt      (pq_cnt),
    .find_hit (pq_hit),
    .find_pos (pq_pos)
  );

  logic [3:0]  hi;
  logic        chan_ok;
  logic [13:0] vel_level;

  assign hi        = st_r[7:4];
  assign chan_ok   = omni_r || hi == vam_pkg::ST_SYSTEM || st_r[3:0] == channel_r;
  assign vel_level = pfx_valid_r ? ({d2_r[6:0], 7'd0} + {7'd0, pfx_r})
                                 : {d2_r[6:0], 7'd0};

  assign busy      = state_r != vam_pkg::S_IDLE;
  assign cfg_ready = !busy;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      vam_pkg::S_IDLE: begin
        if (start) state_nxt = vam_pkg::S_DEC;
      end
      vam_pkg::S_DEC: begin
        state_nxt = vam_pkg::S_IDLE;
        if (func_r) begin
          state_nxt = vam_pkg::S_REP;
        end else if (st_r[7] && chan_ok) begin
          case (hi)
            vam_pkg::ST_NOTE_OFF, vam_pkg::ST_NOTE_ON, vam_pkg::ST_POLY_AT: begin
              if (!d1_r[7] && !d2_r[7]) state_nxt = vam_pkg::S_SCAN;
            end
            vam_pkg::ST_CTRL: begin
              if ((d1_r == vam_pkg::CC_SOUND_OFF || d1_r == vam_pkg::CC_NOTES_OFF ||
                   d1_r == vam_pkg::CC_OMNI_OFF || d1_r == vam_pkg::CC_OMNI_ON ||
                   d1_r == vam_pkg::CC_MONO_ON || d1_r == vam_pkg::CC_POLY_ON) &&
                  sq_cnt != '0) begin
                state_nxt = vam_pkg::S_ANO_EMIT;
              end
            end
            default: state_nxt = vam_pkg::S_IDLE;
          endcase
        end
      end
      vam_pkg::S_SCAN: begin
        if (idx_r == CW'(NV)) state_nxt = vam_pkg::S_ACT;
      end
      vam_pkg::S_ACT: begin
        state_nxt = vam_pkg::S_IDLE;
        case (op_r)
          vam_pkg::OP_OFF: begin
            if (mono_r ? match0_r : (found_r && sq_hit)) state_nxt = vam_pkg::S_WR;
          end
          vam_pkg::OP_ON: begin
            if (mono_r || found_r || pq_cnt != '0 || sq_cnt != '0) begin
              state_nxt = vam_pkg::S_WR;
            end
          end
          vam_pkg::OP_PRESS: begin
            if (found_r) state_nxt = vam_pkg::S_WR;
          end
          default: state_nxt = vam_pkg::S_IDLE;
        endcase
      end
      vam_pkg::S_WR:       state_nxt = vam_pkg::S_IDLE;
      vam_pkg::S_REP: begin
        if (idx_r == CW'(NV)) state_nxt = vam_pkg::S_IDLE;
      end
      vam_pkg::S_ANO_EMIT: begin
        if (idx_r == k_r) state_nxt = vam_pkg::S_ANO_PUSH;
      end
      vam_pkg::S_ANO_PUSH: begin
        if (idx_r == CW'(1)) state_nxt = vam_pkg::S_IDLE;
      end
      default: state_nxt = vam_pkg::S_IDLE;
    endcase
  end

  // Datapath, memory and queue control.
  always_comb begin
    op_nxt        = op_r;
    pitch_nxt     = pitch_r;
    level_nxt     = level_r;
    idx_nxt       = idx_r;
    k_nxt         = k_r;
    found_nxt     = found_r;
    fv_nxt        = fv_r;
    match0_nxt    = match0_r;
    vcur_nxt      = vcur_r;
    pfx_valid_nxt = pfx_valid_r;
    pfx_nxt       = pfx_r;
    omni_nxt      = omni_r;
    mono_nxt      = mono_r;

    ov_nxt   = 1'b0;
    ok_nxt   = ok_r;
    ovc_nxt  = ovc_r;
    og_nxt   = og_r;
    orec_nxt = orec_r;
    ol_nxt   = 1'b0;

    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = vcur_r;
    wr_data = rd_data;
    mem_clr = 1'b0;
    sq_op   = '0;
    pq_op   = '0;

    case (state_r)
      vam_pkg::S_DEC: begin
        pitch_nxt = vam_pkg::to_pitch(d1_r[6:0], key_root_r, chromatic_r);
        idx_nxt   = '0;
        found_nxt = 1'b0;
        fv_nxt    = '0;
        k_nxt     = sq_cnt;
        if (!func_r && st_r[7] && chan_ok) begin
          case (hi)
            vam_pkg::ST_NOTE_OFF, vam_pkg::ST_NOTE_ON: begin
              if (!d1_r[7] && !d2_r[7]) begin
                pfx_valid_nxt = 1'b0;
                if (hi == vam_pkg::ST_NOTE_OFF) begin
                  op_nxt    = vam_pkg::OP_OFF;
                  level_nxt = vel_level;
                end else if (vel_level == '0) begin
                  // velocity zero acts as a release at one half
                  op_nxt    = vam_pkg::OP_OFF;
                  level_nxt = vam_pkg::HALF_LEVEL;
                end else begin
                  op_nxt    = vam_pkg::OP_ON;
                  level_nxt = vel_level;
                end
              end
            end
            vam_pkg::ST_POLY_AT: begin
              op_nxt    = vam_pkg::OP_PRESS;
              level_nxt = {d2_r[6:0], 7'd0};
            end
            vam_pkg::ST_CTRL: begin
              if (!d1_r[7]) begin
                case (d1_r)
                  vam_pkg::CC_HIRES_VEL: begin
                    if (!d2_r[7]) begin
                      pfx_nxt       = d2_r[6:0];
                      pfx_valid_nxt = 1'b1;
                    end
                  end
                  vam_pkg::CC_SOUND_OFF: mem_clr  = 1'b1;
                  vam_pkg::CC_OMNI_OFF:  omni_nxt = 1'b0;
                  vam_pkg::CC_OMNI_ON:   omni_nxt = 1'b1;
                  vam_pkg::CC_MONO_ON:   mono_nxt = 1'b1;
                  vam_pkg::CC_POLY_ON:   mono_nxt = 1'b0;
                  default: ;
                endcase
              end
            end
            default: ;
          endcase
        end
      end

      // Read every entry; compare each one when its registered read data returns.
      vam_pkg::S_SCAN: begin
        if (idx_r < CW'(NV)) begin
          rd_en   = 1'b1;
          rd_addr = idx_r[VW-1:0];
        end
        if (idx_r != '0) begin
          if (rd_data.pitch == pitch_r && !found_r) begin
            found_nxt = 1'b1;
            fv_nxt    = VW'(idx_r - 1'b1);
          end
          if (idx_r == CW'(1)) match0_nxt = rd_data.pitch == pitch_r;
        end
        idx_nxt = idx_r + 1'b1;
      end

      // Pick the voice, update the queues and fetch its record.
      vam_pkg::S_ACT: begin
        vcur_nxt = fv_r;
        case (op_r)
          vam_pkg::OP_OFF: begin
            if (mono_r) begin
              vcur_nxt = '0;
            end else if (found_r && sq_hit) begin
              sq_op.rm       = 1'b1;
              sq_op.rm_pos   = sq_pos;
              pq_op.push     = 1'b1;
              pq_op.push_val = fv_r;
            end
          end
          vam_pkg::OP_ON: begin
            if (mono_r) begin
              vcur_nxt = '0;
            end else if (found_r) begin
              if (sq_hit) begin
                sq_op.rm       = 1'b1;
                sq_op.rm_pos   = sq_pos;
                sq_op.push     = 1'b1;
                sq_op.push_val = fv_r;
              end else if (pq_hit) begin
                pq_op.rm       = 1'b1;
                pq_op.rm_pos   = pq_pos;
                sq_op.push     = 1'b1;
                sq_op.push_val = fv_r;
              end
            end else if (pq_cnt != '0) begin
              // oldest stopped voice
              vcur_nxt       = pq[0];
              pq_op.rm       = 1'b1;
              sq_op.push     = 1'b1;
              sq_op.push_val = pq[0];
            end else begin
              // steal the oldest started voice
              vcur_nxt       = sq[0];
              sq_op.rm       = 1'b1;
              sq_op.push     = 1'b1;
              sq_op.push_val = sq[0];
            end
          end
          default: ;
        endcase
        rd_en   = 1'b1;
        rd_addr = vcur_nxt;
      end

      // Modify the fetched record, write it back and report it unless it is an aftertouch.
      vam_pkg::S_WR: begin
        wr_en   = 1'b1;
        wr_addr = vcur_r;
        case (op_r)
          vam_pkg::OP_ON: begin
            wr_data.pitch  = pitch_r;
            wr_data.attack = level_r;
          end
          vam_pkg::OP_OFF:   wr_data.release_lvl = level_r;
          vam_pkg::OP_PRESS: wr_data.pressure    = level_r;
          default: ;
        endcase
        if (op_r != vam_pkg::OP_PRESS) begin
          ov_nxt   = 1'b1;
          ok_nxt   = 1'b0;
          ovc_nxt  = vcur_r;
          og_nxt   = (op_r == vam_pkg::OP_ON) ? vam_pkg::GATE_ON : vam_pkg::GATE_OFF;
          orec_nxt = wr_data;
          ol_nxt   = 1'b1;
        end
      end

      vam_pkg::S_REP: begin
        if (idx_r < CW'(NV)) begin
          rd_en   = 1'b1;
          rd_addr = idx_r[VW-1:0];
        end
        if (idx_r != '0) begin
          ov_nxt   = 1'b1;
          ok_nxt   = 1'b1;
          ovc_nxt  = VW'(idx_r - 1'b1);
          og_nxt   = vam_pkg::GATE_NIL;
          orec_nxt = rd_data;
          ol_nxt   = idx_r == CW'(NV);
        end
        idx_nxt = idx_r + 1'b1;
      end

      // Release every started voice, oldest first.
      vam_pkg::S_ANO_EMIT: begin
        if (idx_r < k_r) begin
          rd_en    = 1'b1;
          rd_addr  = sq[idx_r[VW-1:0]];
          vcur_nxt = sq[idx_r[VW-1:0]];
        end
        if (idx_r != '0) begin
          ov_nxt   = 1'b1;
          ok_nxt   = 1'b0;
          ovc_nxt  = vcur_r;
          og_nxt   = vam_pkg::GATE_OFF;
          orec_nxt = rd_data;
          ol_nxt   = idx_r == k_r;
        end
        idx_nxt = (idx_r == k_r) ? k_r : idx_r + 1'b1;
      end

      // Move them to the stopped queue, newest first, then empty the started one.
      vam_pkg::S_ANO_PUSH: begin
        pq_op.push     = 1'b1;
        pq_op.push_val = sq[VW'(idx_r - 1'b1)];
        sq_op.clr      = idx_r == CW'(1);
        idx_nxt        = idx_r - 1'b1;
      end

      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= vam_pkg::S_IDLE;
      pfx_valid_r <= 1'b0;
      omni_r      <= 1'b0;
      mono_r      <= 1'b0;
      ov_r        <= 1'b0;
      key_root_r  <= 7'd60;
      chromatic_r <= 1'b1;
      channel_r   <= 4'd0;
      idx_r       <= '0;
      k_r         <= '0;
      found_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pfx_valid_r <= pfx_valid_nxt;
      omni_r      <= omni_nxt;
      mono_r      <= mono_nxt;
      ov_r        <= ov_nxt;
      idx_r       <= idx_nxt;
      k_r         <= k_nxt;
      found_r     <= found_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          vam_pkg::REG_KEY_ROOT:  key_root_r  <= cfg_data;
          vam_pkg::REG_CHROMATIC: chromatic_r <= cfg_data[0];
          vam_pkg::REG_CHANNEL:   channel_r   <= cfg_data[3:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers: no reset.
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      func_r <= in_func;
      st_r   <= in_status_byte;
      d1_r   <= in_data_one;
      d2_r   <= in_data_two;
    end
    op_r     <= op_nxt;
    pitch_r  <= pitch_nxt;
    level_r  <= level_nxt;
    fv_r     <= fv_nxt;
    match0_r <= match0_nxt;
    vcur_r   <= vcur_nxt;
    pfx_r    <= pfx_nxt;
    ok_r     <= ok_nxt;
    ovc_r    <= ovc_nxt;
    og_r     <= og_nxt;
    orec_r   <= orec_nxt;
    ol_r     <= ol_nxt;
  end

  assign out_valid          = ov_r;
  assign out_kind           = ok_r;
  assign out_voice          = ovc_r;
  assign out_gate           = $signed(og_r);
  assign out_pitch          = orec_r.pitch;
  assign out_attack_level   = orec_r.attack;
  assign out_release_level  = orec_r.release_lvl;
  assign out_pressure_level = orec_r.pressure;
  assign out_last           = ov_r && ol_r;

  // Outside the push-back sweep the two queue counts add up to the number of voices.
  a_queue_partition: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != vam_pkg::S_ANO_PUSH |-> (5'(sq_cnt) + 5'(pq_cnt)) == 5'(NV))
    else $error("voice queues lost or duplicated a voice");

  // An accepted item always leaves idle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted item did not start work");

  // Nothing follows the final result of an item on the next cycle.
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |=> !out_valid)
    else $error("result after last");

  // Results only come out of work in progress.
  a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r != vam_pkg::S_IDLE))
    else $error("result without an item in work");

endmodule

[sv/vam_mem.sv]
module vam_mem (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 rd_en,
  input  logic [vam_pkg::VIDX_W-1:0]           rd_addr,
  output vam_pkg::voice_rec_t                  rd_data,
  input  logic                                 wr_en,
  input  logic [vam_pkg::VIDX_W-1:0]           wr_addr,
  input  vam_pkg::voice_rec_t                  wr_data,
  input  logic                                 clr
);

  vam_pkg::voice_rec_t                  mem [vam_pkg::NUM_VOICES];
  logic [vam_pkg::NUM_VOICES-1:0]       valid_r;
  vam_pkg::voice_rec_t                  rd_data_r;

  // An entry never written since reset or a clear reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= valid_r[rd_addr] ? mem[rd_addr] : '0;
    end
  end

  assign rd_data = rd_data_r;

endmodule

[sv/vam_queue.sv]
module vam_queue #(
  parameter bit FILL_ON_RESET = 1'b0
) (
  input  logic                                                   clk,
  input  logic                                                   rst_n,
  input  vam_pkg::q_op_t                                         op,
  input  logic [vam_pkg::VIDX_W-1:0]                             find_val,
  output logic [vam_pkg::NUM_VOICES-1:0][vam_pkg::VIDX_W-1:0]    entries,
  output logic [vam_pkg::CNT_W-1:0]                              cnt,
  output logic                                                   find_hit,
  output logic [vam_pkg::VIDX_W-1:0]                             find_pos
);

  logic [vam_pkg::NUM_VOICES-1:0][vam_pkg::VIDX_W-1:0] q_r, q_nxt;
  logic [vam_pkg::CNT_W-1:0]                           cnt_r, cnt_nxt;

  // Remove first, then append at the shortened tail.
  always_comb begin
    q_nxt   = q_r;
    cnt_nxt = cnt_r;
    if (op.clr) begin
      cnt_nxt = '0;
    end else begin
      if (op.rm && cnt_r != '0) begin
        for (int i = 0; i < vam_pkg::NUM_VOICES - 1; i++) begin
          if (i >= int'(op.rm_pos)) begin
            q_nxt[i] = q_r[i+1];
          end
        end
        cnt_nxt = cnt_r - 1'b1;
      end
      if (op.push && cnt_nxt < vam_pkg::CNT_W'(vam_pkg::NUM_VOICES)) begin
        q_nxt[cnt_nxt[vam_pkg::VIDX_W-1:0]] = op.push_val;
        cnt_nxt = cnt_nxt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < vam_pkg::NUM_VOICES; i++) begin
        q_r[i] <= FILL_ON_RESET ? vam_pkg::VIDX_W'(i) : '0;
      end
      cnt_r <= FILL_ON_RESET ? vam_pkg::CNT_W'(vam_pkg::NUM_VOICES) : '0;
    end else begin
      q_r   <= q_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // First occupied slot holding the voice.
  always_comb begin
    find_hit = 1'b0;
    find_pos = '0;
    for (int i = vam_pkg::NUM_VOICES - 1; i >= 0; i--) begin
      if (vam_pkg::CNT_W'(i) < cnt_r && q_r[i] == find_val) begin
        find_hit = 1'b1;
        find_pos = vam_pkg::VIDX_W'(i);
      end
    end
  end

  assign entries = q_r;
  assign cnt     = cnt_r;

endmodule

[tb/sv/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 40;
  localparam int ITEMS_PER_PHASE = 88;

  typedef struct {
    bit       func;
    bit [7:0] st;
    bit [7:0] d1;
    bit [7:0] d2;
  } midi_item_t;

  typedef struct {
    bit                kind;
    bit [2:0]          voice;
    logic signed [1:0] gate;
    logic signed [8:0] pitch;
    bit [13:0]         att;
    bit [13:0]         rel;
    bit [13:0]         prs;
    bit                last;
  } voice_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic              in_func = 1'b0;
  logic [7:0]        in_status_byte = '0;
  logic [7:0]        in_data_one = '0;
  logic [7:0]        in_data_two = '0;
  logic              out_valid;
  logic              out_kind;
  logic [2:0]        out_voice;
  logic signed [1:0] out_gate;
  logic signed [8:0] out_pitch;
  logic [13:0]       out_attack_level;
  logic [13:0]       out_release_level;
  logic [13:0]       out_pressure_level;
  logic              out_last;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [1:0]        cfg_index = '0;
  logic [6:0]        cfg_data = '0;

  midi_voice_allocator_unit dut (.*);

  always #4 clk = ~clk;

  // Pending stimulus and the results it is expected to cause
  midi_item_t    pending_msgs[$];
  voice_result_t expected_results[$];
  int            errors = 0;
  int            cycles = 0;
  int            accepted_cnt = 0;
  int            issued_cnt = 0;

  // Shadow of the allocator: configuration, voice values and both queues
  bit [6:0]  key_root_sh = 7'd60;
  bit        chromatic_sh = 1'b1;
  bit [3:0]  channel_sh = 4'd0;
  int        v_pitch[vam_pkg::NUM_VOICES];
  bit [13:0] v_att[vam_pkg::NUM_VOICES];
  bit [13:0] v_rel[vam_pkg::NUM_VOICES];
  bit [13:0] v_prs[vam_pkg::NUM_VOICES];
  int        sounding_q[$];
  int        silent_q[$];
  bit        prefix_ok = 1'b0;
  bit [6:0]  prefix_val = '0;
  bit        omni_on = 1'b0;
  bit        mono_on = 1'b0;

  initial begin
    for (int i = 0; i < vam_pkg::NUM_VOICES; i++) begin
      v_pitch[i] = 0;
      v_att[i] = '0;
      v_rel[i] = '0;
      v_prs[i] = '0;
      silent_q.push_back(i);
    end
  end

  // Half steps per scale degree within one octave
  function automatic int note_to_pitch(bit [6:0] note);
    int steps[12] = '{0, 1, 2, 3, 4, 6, 7, 8, 9, 10, 11, 12};
    int d, oct, rem;
    d = int'(note) - int'(key_root_sh);
    if (chromatic_sh) return d * 2;
    oct = d / 12;
    rem = d % 12;
    if (rem < 0) begin
      rem += 12;
      oct -= 1;
    end
    return oct * 14 + steps[rem];
  endfunction

  function automatic void push_result(bit kind, int v, int gate);
    voice_result_t r;
    r.kind = kind;
    r.voice = v[2:0];
    r.gate = gate[1:0];
    r.pitch = v_pitch[v][8:0];
    r.att = v_att[v];
    r.rel = v_rel[v];
    r.prs = v_prs[v];
    r.last = 1'b0;
    expected_results.push_back(r);
  endfunction

  function automatic int voice_of_pitch(int p);
    for (int i = 0; i < vam_pkg::NUM_VOICES; i++)
      if (v_pitch[i] == p) return i;
    return -1;
  endfunction

  function automatic int pos_in(ref int q[$], input int v);
    for (int i = 0; i < q.size(); i++)
      if (q[i] == v) return i;
    return -1;
  endfunction

  function automatic void release_note(int p, bit [13:0] level);
    int v, pos;
    if (mono_on) begin
      if (v_pitch[0] != p) return;
      v = 0;
    end else begin
      v = voice_of_pitch(p);
      if (v < 0) return;
      pos = pos_in(sounding_q, v);
      if (pos < 0) return;
      sounding_q.delete(pos);
      silent_q.push_back(v);
    end
    v_rel[v] = level;
    push_result(1'b0, v, -1);
  endfunction

  function automatic void strike_note(int p, bit [13:0] level);
    int v, pos;
    if (level == 0) begin
      release_note(p, vam_pkg::HALF_LEVEL);
      return;
    end
    if (mono_on) begin
      v = 0;
    end else begin
      v = voice_of_pitch(p);
      if (v >= 0) begin
        pos = pos_in(sounding_q, v);
        if (pos >= 0) begin
          sounding_q.delete(pos);
          sounding_q.push_back(v);
        end else begin
          pos = pos_in(silent_q, v);
          if (pos >= 0) begin
            silent_q.delete(pos);
            sounding_q.push_back(v);
          end
        end
      end else if (silent_q.size() > 0) begin
        v = silent_q.pop_front();
        sounding_q.push_back(v);
      end else begin
        // steal the least recently started voice
        v = sounding_q.pop_front();
        sounding_q.push_back(v);
      end
    end
    v_pitch[v] = p;
    v_att[v] = level;
    push_result(1'b0, v, 1);
  endfunction

  // Stop every sounding voice; they rejoin the silent queue newest first
  function automatic void silence_all();
    foreach (sounding_q[i]) push_result(1'b0, sounding_q[i], -1);
    for (int i = sounding_q.size() - 1; i >= 0; i--) silent_q.push_back(sounding_q[i]);
    sounding_q.delete();
  endfunction

  function automatic void process_message(bit [7:0] st, bit [7:0] d1, bit [7:0] d2);
    bit [13:0] level;
    int v;
    if (!st[7]) return;
    if (!omni_on && st[7:4] != vam_pkg::ST_SYSTEM && st[3:0] != channel_sh) return;
    case (st[7:4])
      vam_pkg::ST_NOTE_OFF, vam_pkg::ST_NOTE_ON: begin
        if (d1[7] || d2[7]) return;
        level = prefix_ok ? ({d2[6:0], 7'd0} + prefix_val) : {d2[6:0], 7'd0};
        prefix_ok = 1'b0;
        if (st[7:4] == vam_pkg::ST_NOTE_OFF) release_note(note_to_pitch(d1[6:0]), level);
        else strike_note(note_to_pitch(d1[6:0]), level);
      end
      vam_pkg::ST_POLY_AT: begin
        if (d1[7] || d2[7]) return;
        v = voice_of_pitch(note_to_pitch(d1[6:0]));
        if (v >= 0) v_prs[v] = {d2[6:0], 7'd0};
      end
      vam_pkg::ST_CTRL: begin
        if (d1[7]) return;
        case (d1)
          vam_pkg::CC_HIRES_VEL: begin
            if (d2[7]) return;
            prefix_val = d2[6:0];
            prefix_ok = 1'b1;
          end
          vam_pkg::CC_SOUND_OFF: begin
            for (int i = 0; i < vam_pkg::NUM_VOICES; i++) begin
              v_pitch[i] = 0;
              v_att[i] = '0;
              v_rel[i] = '0;
              v_prs[i] = '0;
            end
            silence_all();
          end
          vam_pkg::CC_NOTES_OFF: silence_all();
          vam_pkg::CC_OMNI_OFF: begin
            omni_on = 1'b0;
            silence_all();
          end
          vam_pkg::CC_OMNI_ON: begin
            omni_on = 1'b1;
            silence_all();
          end
          vam_pkg::CC_MONO_ON: begin
            mono_on = 1'b1;
            silence_all();
          end
          vam_pkg::CC_POLY_ON: begin
            mono_on = 1'b0;
            silence_all();
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  endfunction

  function automatic void predict_results(midi_item_t it);
    int n0;
    n0 = expected_results.size();
    if (it.func) begin
      for (int i = 0; i < vam_pkg::NUM_VOICES; i++) push_result(1'b1, i, 0);
    end else begin
      process_message(it.st, it.d1, it.d2);
    end
    if (expected_results.size() > n0)
      expected_results[expected_results.size() - 1].last = 1'b1;
  endfunction

  function automatic void check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endfunction

  // Sample everything at the rising edge: results first, then new transfers
  always @(posedge clk) begin
    midi_item_t    it;
    voice_result_t e;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else if (rst_n) begin
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          $error("result on voice %0d with nothing expected", out_voice);
          errors++;
        end else begin
          e = expected_results.pop_front();
          check_field("kind", e.kind, out_kind);
          check_field("voice", e.voice, out_voice);
          check_field("gate", e.gate, out_gate);
          check_field("pitch", e.pitch, out_pitch);
          check_field("attack_level", e.att, out_attack_level);
          check_field("release_level", e.rel, out_release_level);
          check_field("pressure_level", e.prs, out_pressure_level);
          check_field("last", e.last, out_last);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          vam_pkg::REG_KEY_ROOT:  key_root_sh = cfg_data;
          vam_pkg::REG_CHROMATIC: chromatic_sh = cfg_data[0];
          vam_pkg::REG_CHANNEL:   channel_sh = cfg_data[3:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        it.func = in_func;
        it.st = in_status_byte;
        it.d1 = in_data_one;
        it.d2 = in_data_two;
        predict_results(it);
        accepted_cnt++;
      end
    end
  end

  // Driver: bursts of back-to-back items separated by random gaps
  int gap_left = 0;
  int burst_left = 4;
  always @(negedge clk) begin
    midi_item_t it;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && accepted_cnt != issued_cnt) begin
      // hold the item until the block takes it
    end else if (gap_left > 0) begin
      start <= 1'b0;
      gap_left--;
    end else if (pending_msgs.size() > 0) begin
      it = pending_msgs.pop_front();
      start <= 1'b1;
      in_func <= it.func;
      in_status_byte <= it.st;
      in_data_one <= it.d1;
      in_data_two <= it.d2;
      issued_cnt++;
      burst_left--;
      if (burst_left <= 0) begin
        burst_left = $urandom_range(1, 12);
        gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 15);
      end
    end else begin
      start <= 1'b0;
    end
  end

  function automatic void queue_item(bit func, bit [7:0] st, bit [7:0] d1, bit [7:0] d2);
    midi_item_t it;
    it.func = func;
    it.st = st;
    it.d1 = d1;
    it.d2 = d2;
    pending_msgs.push_back(it);
  endfunction

  function automatic void queue_random_item();
    bit [7:0] cc_set[6] = '{vam_pkg::CC_SOUND_OFF, vam_pkg::CC_NOTES_OFF,
                            vam_pkg::CC_OMNI_OFF, vam_pkg::CC_OMNI_ON,
                            vam_pkg::CC_MONO_ON, vam_pkg::CC_POLY_ON};
    bit [3:0] ch;
    bit [7:0] note, vel;
    int r, k;
    r = $urandom_range(99);
    ch = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : channel_sh;
    note = ($urandom_range(4) == 0) ? 8'($urandom_range(127))
                                    : 8'((key_root_sh + $urandom_range(11)) % 128);
    vel = ($urandom_range(9) == 0) ? 8'd0 : 8'($urandom_range(127));
    if (r < 8) begin
      queue_item(1'b1, 8'($urandom), 8'($urandom), 8'($urandom));
    end else if (r < 16) begin
      // noise: any byte pattern at all
      queue_item(1'b0, 8'($urandom), 8'($urandom), 8'($urandom));
    end else if (r < 52) begin
      queue_item(1'b0, {vam_pkg::ST_NOTE_ON, ch}, note, vel);
    end else if (r < 78) begin
      queue_item(1'b0, {vam_pkg::ST_NOTE_OFF, ch}, note, vel);
    end else if (r < 85) begin
      queue_item(1'b0, {vam_pkg::ST_POLY_AT, ch}, note, 8'($urandom_range(127)));
    end else if (r < 92) begin
      queue_item(1'b0, {vam_pkg::ST_CTRL, ch}, vam_pkg::CC_HIRES_VEL,
                 8'($urandom_range(127)));
    end else if (r < 96) begin
      k = $urandom_range(5);
      queue_item(1'b0, {vam_pkg::ST_CTRL, ch}, cc_set[k], 8'($urandom_range(127)));
    end else begin
      queue_item(1'b0, {vam_pkg::ST_CTRL, ch}, 8'($urandom_range(127)),
                 8'($urandom_range(127)));
    end
  endfunction

  task automatic wait_quiet();
    while (pending_msgs.size() > 0 || start || expected_results.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [6:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    bit [6:0] roots[5] = '{7'd0, 7'd127, 7'd127, 7'd64, 7'd60};
    bit       chroms[5] = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b1};
    bit [3:0] chans[5] = '{4'd15, 4'd3, 4'd9, 4'd0, 4'd6};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset settings: channel 0, root 60, semitones
    queue_item(1'b1, 8'hFF, 8'hFF, 8'hFF);
    queue_item(1'b0, {vam_pkg::ST_NOTE_ON, 4'd0}, 8'd60, 8'd100);  // matches unplayed voice
    queue_item(1'b0, {vam_pkg::ST_NOTE_ON, 4'd0}, 8'd127, 8'd127);
    queue_item(1'b0, {vam_pkg::ST_NOTE_ON, 4'd0}, 8'd0, 8'd1);
    queue_item(1'b0, {vam_pkg::ST_CTRL, 4'd0}, vam_pkg::CC_HIRES_VEL, 8'h7F);
    queue_item(1'b0, {vam_pkg::ST_NOTE_ON, 4'd0}, 8'd64, 8'h7F);   // consumes prefix
    queue_item(1'b0, {vam_pkg::ST_NOTE_ON, 4'd0}, 8'd64, 8'd0);    // zero velocity releases
    queue_item(1'b0, {vam_pkg::ST_NOTE_OFF, 4'd0}, 8'd50, 8'd10);  // no such voice
    queue_item(1'b0, {vam_pkg::ST_POLY_AT, 4'd0}, 8'd127, 8'h55);
    queue_item(1'b0, {vam_pkg::ST_POLY_AT, 4'd0}, 8'h80, 8'd5);    // malformed, dropped
    queue_item(1'b0, {vam_pkg::ST_NOTE_ON, 4'd0}, 8'd70, 8'h90);   // malformed, dropped
    queue_item(1'b0, {vam_pkg::ST_CTRL, 4'd0}, 8'hFF, 8'd0);
    queue_item(1'b0, 8'h45, 8'd60, 8'd60);                         // data byte as status
    queue_item(1'b0, {vam_pkg::ST_NOTE_ON, 4'd1}, 8'd61, 8'd60);   // other channel
    queue_item(1'b0, 8'hF3, 8'd1, 8'd2);
    queue_item(1'b1, 8'h00, 8'h00, 8'h00);
    queue_item(1'b0, {vam_pkg::ST_CTRL, 4'd0}, vam_pkg::CC_MONO_ON, 8'd0);
    queue_item(1'b0, {vam_pkg::ST_NOTE_ON, 4'd0}, 8'd70, 8'd50);
    queue_item(1'b0, {vam_pkg::ST_NOTE_OFF, 4'd0}, 8'd71, 8'd0);
    queue_item(1'b0, {vam_pkg::ST_NOTE_OFF, 4'd0}, 8'd70, 8'd3);
    queue_item(1'b0, {vam_pkg::ST_CTRL, 4'd0}, vam_pkg::CC_POLY_ON, 8'd0);
    queue_item(1'b0, {vam_pkg::ST_CTRL, 4'd0}, vam_pkg::CC_OMNI_ON, 8'd0);
    queue_item(1'b0, {vam_pkg::ST_NOTE_ON, 4'd5}, 8'd62, 8'd30);
    queue_item(1'b0, {vam_pkg::ST_CTRL, 4'd0}, vam_pkg::CC_SOUND_OFF, 8'd0);
    queue_item(1'b0, {vam_pkg::ST_CTRL, 4'd0}, vam_pkg::CC_OMNI_OFF, 8'd0);
    wait_quiet();

    // Random phases, each under fresh settings including the extremes
    for (int p = 0; p < 5; p++) begin
      write_reg(vam_pkg::REG_KEY_ROOT, roots[p]);
      write_reg(vam_pkg::REG_CHROMATIC, {6'd0, chroms[p]});
      write_reg(vam_pkg::REG_CHANNEL, {3'd0, chans[p]});
      for (int i = 0; i < ITEMS_PER_PHASE; i++) queue_random_item();
      wait_quiet();
    end

    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
